@@ rtl/core/atfe_pkg.sv @@
package atfe_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 8;
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned KIND_W = 8;

  typedef enum logic [1:0] {
    FuncRemember = 2'd0,
    FuncKnown    = 2'd1,
    FuncForget   = 2'd2
  } func_e;

  // one table slot
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [KIND_W-1:0] kind;
  } entry_t;

  // request broadcast to every cell, already qualified by accept and nonzero address
  typedef struct packed {
    logic              remember;
    logic              forget;
    logic [ADDR_W-1:0] addr;
    logic [KIND_W-1:0] kind;
  } cmd_t;

  // status rippling from older to newer slots
  typedef struct packed {
    logic hit;
    logic free_seen;
    logic changed;
  } chain_t;

  // table-wide status fed back to every cell
  typedef struct packed {
    logic any_hit;
    logic full;
  } glob_t;

endpackage

@@ rtl/core/atfe_cell.sv @@
module atfe_cell import atfe_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cmd_t   cmd_i,
  input  glob_t  glob_i,
  input  chain_t chain_i,
  output chain_t chain_o,
  input  entry_t upper_i,
  output entry_t entry_o
);

  logic   valid_q, valid_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic   hit;
  logic   first_hit;
  logic   first_free;

  assign hit        = valid_q && (addr_q == cmd_i.addr);
  assign first_hit  = hit && !chain_i.hit;
  assign first_free = !valid_q && !chain_i.free_seen;

  assign chain_o.hit       = chain_i.hit || hit;
  assign chain_o.free_seen = chain_i.free_seen || !valid_q;
  assign chain_o.changed   = chain_i.changed || (first_hit && (kind_q != cmd_i.kind));

  assign entry_o = '{valid: valid_q, addr: addr_q, kind: kind_q};

  always_comb begin
    valid_d = valid_q;
    addr_d  = addr_q;
    kind_d  = kind_q;
    if (cmd_i.forget && (chain_i.hit || hit)) begin
      // close the gap from the matching slot upward
      valid_d = upper_i.valid;
      addr_d  = upper_i.addr;
      kind_d  = upper_i.kind;
    end else if (cmd_i.remember) begin
      if (glob_i.any_hit) begin
        if (first_hit) begin
          kind_d = cmd_i.kind;
        end
      end else if (!glob_i.full) begin
        if (first_free) begin
          valid_d = 1'b1;
          addr_d  = cmd_i.addr;
          kind_d  = cmd_i.kind;
        end
      end else begin
        // full: whole row moves down, oldest drops out
        valid_d = upper_i.valid;
        addr_d  = upper_i.addr;
        kind_d  = upper_i.kind;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    kind_q <= kind_d;
  end

endmodule

@@ rtl/core/address_table_fifo_evict_unit.sv @@
// Peer address table of TableSlots entries held in a row of cells, oldest in
// slot 0. Every word is handled by the whole row together: all cells compare the
// address at once, a hit/free chain through the row picks the slot, and the
// row shifts down on forget or on remember into a full table. One word is
// accepted per cycle; the answer appears in the next cycle in an output
// register, and a new word is still taken while that answer waits unless the
// output side stalls. func 0 remembers (answer: table changed), 1 asks whether
// the address is known, 2 forgets (answer: removed). An all-zero address or
// an unused func leaves the table alone and answers 0.
module address_table_fifo_evict_unit import atfe_pkg::*; #(
  parameter int unsigned TableSlots = TABLE_SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        func_i,
  input  logic [ADDR_W-1:0] peer_address_i,
  input  logic [KIND_W-1:0] peer_kind_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              answer_o
);

  logic   in_accept;
  logic   addr_ok;
  logic   out_valid_q, out_valid_d;
  logic   answer_q, answer_d;
  cmd_t   cmd;
  glob_t  glob;
  entry_t top_entry;
  chain_t chain [TableSlots+1];
  entry_t entries [TableSlots];
  logic [TableSlots-1:0] valid_vec;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign addr_ok    = (peer_address_i != '0);

  assign cmd.remember = in_accept && addr_ok && (func_i == FuncRemember);
  assign cmd.forget   = in_accept && addr_ok && (func_i == FuncForget);
  assign cmd.addr     = peer_address_i;
  assign cmd.kind     = peer_kind_i;

  // fed into the newest slot: new entry on eviction, empty slot on forget
  assign top_entry = '{valid: cmd.remember, addr: peer_address_i, kind: peer_kind_i};

  assign chain[0] = '{hit: 1'b0, free_seen: 1'b0, changed: 1'b0};

  for (genvar i = 0; i < TableSlots; i++) begin : g_cell
    atfe_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .glob_i  (glob),
      .chain_i (chain[i]),
      .chain_o (chain[i+1]),
      .upper_i ((i == TableSlots - 1) ? top_entry : entries[(i + 1) % TableSlots]),
      .entry_o (entries[i])
    );
    assign valid_vec[i] = entries[i].valid;
  end

  assign glob.any_hit = chain[TableSlots].hit;
  assign glob.full    = !chain[TableSlots].free_seen;

  always_comb begin
    answer_d    = answer_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (in_accept) begin
      out_valid_d = 1'b1;
      answer_d    = 1'b0;
      if (addr_ok) begin
        case (func_i)
          FuncRemember: answer_d = glob.any_hit ? chain[TableSlots].changed : 1'b1;
          FuncKnown:    answer_d = glob.any_hit;
          FuncForget:   answer_d = glob.any_hit;
          default:      answer_d = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    answer_q <= answer_d;
  end

  assign out_valid_o = out_valid_q;
  assign answer_o    = answer_q;

`ifndef SYNTHESIS
  // every accepted word leaves a result behind
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_accept |=> out_valid_o)
    else $error("accepted word produced no result");

  // zero address never answers true
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !addr_ok) |=> !answer_o)
    else $error("zero address answered true");

  // occupied slots always form one block starting at slot 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + TableSlots'(1'b1))) == '0)
    else $error("gap in occupied slots");

  // a result taken while nothing is accepted leaves the output empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !in_accept) |=> !out_valid_o)
    else $error("result delivered twice");
`endif

endmodule

@@ dv/tb_address_table_fifo_evict_unit.sv @@
`timescale 1ns / 1ps

module tb_address_table_fifo_evict_unit;
  import atfe_pkg::*;

  localparam int unsigned SLOTS = TABLE_SLOTS_DEF;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 3000;
  localparam int BURST_CYCLES = 150;
  localparam logic [ADDR_W-1:0] ADDR_ONES = {ADDR_W{1'b1}};

  typedef struct {
    logic [1:0]        func;
    logic [ADDR_W-1:0] addr;
    logic [KIND_W-1:0] kind;
  } word_t;

  logic              clk = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [1:0]        func_i = '0;
  logic [ADDR_W-1:0] peer_address_i = '0;
  logic [KIND_W-1:0] peer_kind_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              answer_o;

  word_t             pending_words[$];
  logic              answer_queue[$];
  logic [ADDR_W-1:0] addr_pool[12];

  // predicted table contents, slot 0 is the oldest
  logic              slot_valid[SLOTS];
  logic [ADDR_W-1:0] slot_addr[SLOTS];
  logic [KIND_W-1:0] slot_kind[SLOTS];

  bit word_taken = 1'b0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int burst_reqs = 0;
  int errors = 0;
  int quiet_cycles = 0;

  address_table_fifo_evict_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .peer_address_i (peer_address_i),
    .peer_kind_i    (peer_kind_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .answer_o       (answer_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int find_slot(logic [ADDR_W-1:0] addr);
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_valid[i] && slot_addr[i] == addr) return i;
    end
    return -1;
  endfunction

  // shift everything above the slot down one place and clear the top slot
  function automatic void drop_slot(int s);
    for (int i = s; i < SLOTS - 1; i++) begin
      slot_valid[i] = slot_valid[i+1];
      slot_addr[i]  = slot_addr[i+1];
      slot_kind[i]  = slot_kind[i+1];
    end
    slot_valid[SLOTS-1] = 1'b0;
    slot_addr[SLOTS-1]  = '0;
    slot_kind[SLOTS-1]  = '0;
  endfunction

  function automatic logic predict_answer(logic [1:0] func, logic [ADDR_W-1:0] addr,
                                          logic [KIND_W-1:0] kind);
    int hit;
    int free_slot;
    hit = find_slot(addr);
    free_slot = -1;
    if (addr == '0) return 1'b0;
    case (func)
      FuncRemember: begin
        if (hit >= 0) begin
          if (slot_kind[hit] == kind) return 1'b0;
          slot_kind[hit] = kind;
          return 1'b1;
        end
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!slot_valid[i]) free_slot = i;
        end
        if (free_slot < 0) begin
          drop_slot(0);
          free_slot = SLOTS - 1;
        end
        slot_valid[free_slot] = 1'b1;
        slot_addr[free_slot]  = addr;
        slot_kind[free_slot]  = kind;
        return 1'b1;
      end
      FuncKnown: return hit >= 0;
      FuncForget: begin
        if (hit < 0) return 1'b0;
        drop_slot(hit);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic word_t random_word();
    word_t w;
    int r;
    r = $urandom_range(99);
    if (r < 45) w.func = FuncRemember;
    else if (r < 70) w.func = FuncKnown;
    else if (r < 93) w.func = FuncForget;
    else w.func = FUNC_UNUSED;
    r = $urandom_range(99);
    if (r < 6) w.addr = '0;
    else if (r < 85) w.addr = addr_pool[$urandom_range(11)];
    else w.addr = ADDR_W'({$urandom(), $urandom()});
    // a few kinds only, so that repeated remembers often leave the type alone
    if ($urandom_range(99) < 60) w.kind = KIND_W'($urandom_range(3));
    else w.kind = KIND_W'($urandom_range(255));
    return w;
  endfunction

  task automatic add_word(logic [1:0] func, logic [ADDR_W-1:0] addr, logic [KIND_W-1:0] kind);
    word_t w;
    w.func = func;
    w.addr = addr;
    w.kind = kind;
    pending_words.push_back(w);
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || in_valid_i || answer_queue.size() != 0)
      @(negedge clk);
  endtask

  // sender: a word stays on the bus until it is taken
  always @(negedge clk) begin : drive_words
    word_t w;
    if (rst_ni && (!in_valid_i || word_taken)) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = pending_words.pop_front();
        in_valid_i     <= 1'b1;
        func_i         <= w.func;
        peer_address_i <= w.addr;
        peer_kind_i    <= w.kind;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin : drive_stall
    int burst_left;
    int burst_served;
    if (burst_left > 0) begin
      burst_left--;
      out_stall_i <= 1'b1;
    end else if (burst_served != burst_reqs) begin
      burst_served++;
      burst_left = BURST_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= $urandom_range(99) < recv_idle_pct;
    end
  end

  always @(posedge clk) begin : check_answers
    logic exp_answer;
    bit answer_taken;
    if (rst_ni) begin
      word_taken = in_valid_i && !in_stall_o;
      answer_taken = out_valid_o && !out_stall_i;
      if (word_taken)
        answer_queue.push_back(predict_answer(func_i, peer_address_i, peer_kind_i));
      if (answer_taken) begin
        if (answer_queue.size() == 0) begin
          $error("answer: nothing expected, actual %0b", answer_o);
          errors++;
        end else begin
          exp_answer = answer_queue.pop_front();
          if (answer_o !== exp_answer) begin
            $error("answer: expected %0b, actual %0b", exp_answer, answer_o);
            errors++;
          end
        end
      end
      if (word_taken || answer_taken) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    for (int i = 0; i < SLOTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_addr[i]  = '0;
      slot_kind[i]  = '0;
    end
    foreach (addr_pool[i]) begin
      addr_pool[i] = ADDR_W'({$urandom(), $urandom()});
      if (addr_pool[i] == '0) addr_pool[i] = ADDR_ONES;
    end
    repeat (12) @(posedge clk);
    @(negedge clk) rst_ni = 1'b1;

    // type update, unchanged type, zero address, unused selector
    add_word(FuncRemember, ADDR_ONES, 8'hFF);
    add_word(FuncRemember, ADDR_ONES, 8'hFF);
    add_word(FuncRemember, ADDR_ONES, 8'h00);
    add_word(FuncKnown, ADDR_ONES, 8'h00);
    add_word(FuncKnown, '0, 8'h00);
    add_word(FuncRemember, '0, 8'h05);
    add_word(FuncForget, '0, 8'h00);
    add_word(FUNC_UNUSED, ADDR_ONES, 8'hFF);
    // fill the table, then push the oldest out
    for (int i = 1; i < SLOTS; i++) add_word(FuncRemember, ADDR_W'(i), KIND_W'(i));
    add_word(FuncRemember, 48'h8000_0000_0000, 8'h80);
    add_word(FuncKnown, ADDR_ONES, 8'h00);
    add_word(FuncForget, 48'd4, 8'h00);
    add_word(FuncForget, 48'd4, 8'h00);
    add_word(FuncForget, 48'h8000_0000_0000, 8'h00);
    add_word(FuncForget, 48'd1, 8'h00);
    add_word(FuncKnown, 48'd2, 8'h00);
    add_word(FuncRemember, ADDR_ONES, 8'hAA);
    drain();

    send_idle_pct = 29;
    recv_idle_pct = 86;
    repeat (580) pending_words.push_back(random_word());
    drain();

    send_idle_pct = 86;
    recv_idle_pct = 29;
    repeat (580) pending_words.push_back(random_word());
    drain();

    // back-to-back words against a long output hold-off
    send_idle_pct = 0;
    recv_idle_pct = 0;
    burst_reqs++;
    repeat (590) pending_words.push_back(random_word());
    drain();

    repeat (20) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
